### rtl/srec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srec_pkg;

  localparam logic [7:0] CharNl   = 8'h0A;
  localparam logic [7:0] CharS    = 8'h53;
  localparam logic [7:0] Char0    = 8'h30;
  localparam logic [7:0] Char9    = 8'h39;
  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharF    = 8'h46;
  localparam logic [7:0] HexAlpha = 8'd10;

  localparam int unsigned TdataW = 72;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_CSUM   = 3'd1,
    ST_SYNTAX = 3'd2,
    ST_COUNT  = 3'd3,
    ST_IGNORE = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    PH_WAIT_S = 8'b0000_0001,
    PH_TYPE   = 8'b0000_0010,
    PH_COUNT  = 8'b0000_0100,
    PH_ADDR   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_CSUM   = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic        is_status;
    logic [31:0] word_address;
    logic [31:0] data_word;
    status_e     line_status;
    logic [3:0]  record_kind;
  } res_t;

endpackage

`default_nettype wire

### rtl/srec_hex_dec.sv
`timescale 1ns / 1ps
`default_nettype none

module srec_hex_dec (
  input  logic [7:0] char_i,
  output logic       is_hex_o,
  output logic [3:0] nib_o
);

  logic [7:0] alpha_off;

  assign alpha_off = char_i - srec_pkg::CharA + srec_pkg::HexAlpha;

  always_comb begin
    is_hex_o = 1'b0;
    nib_o    = 4'd0;
    if (char_i >= srec_pkg::Char0 && char_i <= srec_pkg::Char9) begin
      is_hex_o = 1'b1;
      nib_o    = char_i[3:0];
    end else if (char_i >= srec_pkg::CharA && char_i <= srec_pkg::CharF) begin
      is_hex_o = 1'b1;
      nib_o    = alpha_off[3:0];
    end
  end

endmodule

`default_nettype wire

### rtl/srec_core.sv
`timescale 1ns / 1ps
`default_nettype none

module srec_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  input  logic             is_hex_i,
  input  logic [3:0]       nib_i,
  output logic             res_valid_o,
  output srec_pkg::res_t   res_o
);

  srec_pkg::phase_e  phase_q, phase_d;
  srec_pkg::status_e err_q, err_d;
  logic [8:0]  pos_q, pos_d;
  logic [3:0]  type_q, type_d;
  logic [3:0]  ad_q, ad_d;
  logic [7:0]  bc_q, bc_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] word_q, word_d;
  logic [3:0]  wn_q, wn_d;
  logic [7:0]  sum_q, sum_d;
  logic [3:0]  high_q, high_d;
  logic [7:0]  csum_q, csum_d;

  logic [8:0]  pos_new;
  logic [7:0]  bc_new;
  logic [7:0]  bc_min;
  logic [7:0]  data_bytes;
  logic [8:0]  data_total;
  logic [31:0] word_new;
  logic [3:0]  wn_new;
  logic [3:0]  pad_n;
  logic [4:0]  pad_sh;
  logic [31:0] word_pad;
  logic        last_digit;
  logic        type_data;

  assign pos_new    = pos_q + 9'd1;
  assign bc_new     = {bc_q[3:0], nib_i};
  assign bc_min     = {5'd0, ad_q[3:1]} + 8'd1;
  assign data_bytes = bc_q - 8'd1 - {5'd0, ad_q[3:1]};
  assign data_total = {data_bytes, 1'b0};
  assign word_new   = {word_q[27:0], nib_i};
  assign wn_new     = wn_q + 4'd1;
  assign pad_n      = 4'd8 - wn_new;
  assign pad_sh     = {pad_n[2:0], 2'b00};
  assign word_pad   = wn_new[3] ? word_new : (word_new << pad_sh);
  assign last_digit = (pos_new == data_total);
  assign type_data  = (type_q >= 4'd1) && (type_q <= 4'd3);

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    pos_d   = pos_q;
    type_d  = type_q;
    ad_d    = ad_q;
    bc_d    = bc_q;
    addr_d  = addr_q;
    word_d  = word_q;
    wn_d    = wn_q;
    sum_d   = sum_q;
    high_d  = high_q;
    csum_d  = csum_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_i) begin
      if (char_i == srec_pkg::CharNl) begin
        res_valid_o       = 1'b1;
        res_o.is_status   = 1'b1;
        res_o.record_kind = type_q;
        if (err_q != srec_pkg::ST_OK) begin
          res_o.line_status = err_q;
        end else if (phase_q != srec_pkg::PH_DONE) begin
          res_o.line_status = srec_pkg::ST_SYNTAX;
        end else if (csum_q != ~sum_q) begin
          res_o.line_status = srec_pkg::ST_CSUM;
        end else if (!type_data) begin
          res_o.line_status = srec_pkg::ST_IGNORE;
        end else begin
          res_o.line_status = srec_pkg::ST_OK;
        end
        phase_d = srec_pkg::PH_WAIT_S;
        err_d   = srec_pkg::ST_OK;
        pos_d   = '0;
        type_d  = '0;
        ad_d    = '0;
        bc_d    = '0;
        addr_d  = '0;
        word_d  = '0;
        wn_d    = '0;
        sum_d   = '0;
        high_d  = '0;
        csum_d  = '0;
      end else if (phase_q == srec_pkg::PH_WAIT_S) begin
        if (char_i == srec_pkg::CharS) begin
          phase_d = srec_pkg::PH_TYPE;
        end else begin
          err_d   = srec_pkg::ST_SYNTAX;
          phase_d = srec_pkg::PH_SKIP;
        end
      end else if (phase_q != srec_pkg::PH_SKIP && phase_q != srec_pkg::PH_DONE) begin
        if (!is_hex_i) begin
          err_d   = (phase_q == srec_pkg::PH_DATA) ? srec_pkg::ST_COUNT
                                                    : srec_pkg::ST_SYNTAX;
          phase_d = srec_pkg::PH_SKIP;
        end else begin
          if (phase_q == srec_pkg::PH_COUNT || phase_q == srec_pkg::PH_ADDR ||
              phase_q == srec_pkg::PH_DATA) begin
            if (!pos_q[0]) begin
              high_d = nib_i;
            end else begin
              sum_d = sum_q + {high_q, nib_i};
            end
          end
          unique case (phase_q)
            srec_pkg::PH_TYPE: begin
              type_d = nib_i;
              case (nib_i) inside
                4'd1, 4'd5, 4'd9: ad_d = 4'd4;
                4'd2, 4'd6, 4'd8: ad_d = 4'd6;
                default:          ad_d = 4'd8;
              endcase
              pos_d   = '0;
              phase_d = srec_pkg::PH_COUNT;
            end
            srec_pkg::PH_COUNT: begin
              bc_d  = bc_new;
              pos_d = pos_new;
              if (pos_new == 9'd2) begin
                pos_d = '0;
                if (bc_new < bc_min) begin
                  err_d   = srec_pkg::ST_COUNT;
                  phase_d = srec_pkg::PH_SKIP;
                end else begin
                  phase_d = srec_pkg::PH_ADDR;
                end
              end
            end
            srec_pkg::PH_ADDR: begin
              addr_d = {addr_q[27:0], nib_i};
              pos_d  = pos_new;
              if (pos_new == {5'd0, ad_q}) begin
                pos_d   = '0;
                phase_d = (data_total != 9'd0) ? srec_pkg::PH_DATA : srec_pkg::PH_CSUM;
              end
            end
            srec_pkg::PH_DATA: begin
              pos_d  = pos_new;
              word_d = word_new;
              wn_d   = wn_new;
              if (wn_new[3] || last_digit) begin
                if (type_data) begin
                  res_valid_o        = 1'b1;
                  res_o.word_address = addr_q;
                  res_o.data_word    = word_pad;
                  res_o.record_kind  = type_q;
                end
                addr_d = addr_q + 32'd4;
                word_d = '0;
                wn_d   = '0;
              end
              if (last_digit) begin
                pos_d   = '0;
                phase_d = srec_pkg::PH_CSUM;
              end
            end
            srec_pkg::PH_CSUM: begin
              csum_d = {csum_q[3:0], nib_i};
              pos_d  = pos_new;
              if (pos_new == 9'd2) begin
                pos_d   = '0;
                phase_d = srec_pkg::PH_DONE;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= srec_pkg::PH_WAIT_S;
      err_q   <= srec_pkg::ST_OK;
      pos_q   <= '0;
      type_q  <= '0;
      ad_q    <= '0;
      bc_q    <= '0;
      addr_q  <= '0;
      word_q  <= '0;
      wn_q    <= '0;
      sum_q   <= '0;
      high_q  <= '0;
      csum_q  <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      ad_q    <= ad_d;
      bc_q    <= bc_d;
      addr_q  <= addr_d;
      word_q  <= word_d;
      wn_q    <= wn_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
      csum_q  <= csum_d;
    end
  end

  // newline always closes the line with a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && char_i == srec_pkg::CharNl) |-> (res_valid_o && res_o.is_status))
    else $error("newline without status result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && char_i == srec_pkg::CharNl) |=> (phase_q == srec_pkg::PH_WAIT_S &&
                                                 err_q == srec_pkg::ST_OK))
    else $error("line state not cleared after newline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != srec_pkg::ST_OK) |-> (phase_q == srec_pkg::PH_SKIP))
    else $error("error recorded outside skip phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wn_q < 4'd8))
    else $error("word nibble count overflow");

endmodule

`default_nettype wire

### rtl/srec_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module srec_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  srec_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           room_o,
  output logic           valid_o,
  output srec_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  srec_pkg::res_t res_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### rtl/srec_line_parse_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// S-record line checker: takes one ASCII character per transaction and emits
// a 32-bit data word for every eight data digits (or the zero-padded tail of
// the data field) of type 1 to 3 records, plus one status transaction on each
// newline (0 ok, 1 checksum, 2 syntax, 3 byte count, 4 ignored record type).
// One character is taken every cycle while the output side keeps up; a result
// is worked out from the character held in the input register and is then held
// in the output register. The combinational parse step between those registers
// sets the rate.
module srec_line_parse_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [srec_pkg::TdataW-1:0] m_axis_tdata_o,
  // [31:0] word_address, [63:32] data_word, [66:64] line_status,
  // [70:67] record_kind, [71] zero
  output logic        m_axis_tuser_o   // [0] is_status
);

  logic           in_valid_q, in_valid_d;
  logic [7:0]     char_q;
  logic           in_take;
  logic           fire;
  logic           out_room;
  logic           is_hex;
  logic [3:0]     nib;
  logic           res_valid;
  srec_pkg::res_t res;
  srec_pkg::res_t out_res;

  assign fire            = in_valid_q && out_room;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= s_axis_tdata_i;
    end
  end

  srec_hex_dec u_hex_dec (
    .char_i   (char_q),
    .is_hex_o (is_hex),
    .nib_o    (nib)
  );

  srec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_i      (char_q),
    .is_hex_i    (is_hex),
    .nib_i       (nib),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srec_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready_i),
    .room_o  (out_room),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.is_status;
  assign m_axis_tdata_o = {1'b0, out_res.record_kind, out_res.line_status,
                           out_res.data_word, out_res.word_address};

endmodule

`default_nettype wire
